/* src/dsfe_pkg.sv */
package dsfe_pkg;

    localparam logic [7:0] HEAD_BYTE = 8'h55;
    localparam logic [7:0] END_BYTE  = 8'hAA;
    localparam logic [7:0] DLE_BYTE  = 8'h10;

    // longest run of bytes one item can cause: header 3, stuffed data 2,
    // stuffed check 2, end 1
    localparam int RUN_MAX = 8;
    localparam int CNT_W   = 4;
    localparam int IDX_W   = 3;

    typedef logic [RUN_MAX-1:0][7:0] t_run_bytes;

    typedef struct packed {
        t_run_bytes       bytes;
        logic [CNT_W-1:0] count;
        logic             has_end;
    } t_run;

    function automatic logic needs_dle(input logic [7:0] b);
        return (b == HEAD_BYTE) || (b == END_BYTE) || (b == DLE_BYTE);
    endfunction

endpackage

/* src/dsfe_if.sv */
interface dsfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       has_data;
    logic       first;
    logic       last;
    logic [7:0] frame_type;
    logic [7:0] payload_count;

    modport source (
        output valid, payload_byte, has_data, first, last, frame_type, payload_count,
        input  ready
    );
    modport sink (
        input  valid, payload_byte, has_data, first, last, frame_type, payload_count,
        output ready
    );
endinterface

interface dsfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;

    modport source (
        output valid, out_byte, run_last, frame_end,
        input  ready
    );
    modport sink (
        input  valid, out_byte, run_last, frame_end,
        output ready
    );
endinterface

/* src/dsfe_framer.sv */
module dsfe_framer
    import dsfe_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    dsfe_in_if.sink      i_in,
    output logic         o_run_valid,
    output t_run         o_run,
    input  logic         i_run_ready
);

    logic       r_in_frame;
    logic       n_in_frame;
    logic [7:0] r_check;
    logic [7:0] n_check;
    logic       r_run_valid;
    t_run       r_run;
    t_run       n_run;
    logic       accept;

    assign i_in.ready  = !r_run_valid || i_run_ready;
    assign accept      = i_in.valid && i_in.ready;
    assign o_run_valid = r_run_valid;
    assign o_run       = r_run;

    // Lay out the run of bytes for one item in emission order.
    always_comb begin
        logic [CNT_W-1:0] k;
        logic [7:0]       len;
        n_run      = '0;
        n_check    = r_check;
        n_in_frame = r_in_frame;
        k          = '0;
        len        = 8'(i_in.payload_count + 8'd1);

        if (i_in.first) begin
            n_run.bytes[k[IDX_W-1:0]] = HEAD_BYTE;
            k = k + CNT_W'(1);
            n_run.bytes[k[IDX_W-1:0]] = len;
            k = k + CNT_W'(1);
            n_run.bytes[k[IDX_W-1:0]] = i_in.frame_type;
            k = k + CNT_W'(1);
            n_check    = HEAD_BYTE ^ len ^ i_in.frame_type;
            n_in_frame = 1'b1;
        end

        if (n_in_frame) begin
            if (i_in.has_data) begin
                n_check = n_check ^ i_in.payload_byte;
                if (needs_dle(i_in.payload_byte)) begin
                    n_run.bytes[k[IDX_W-1:0]] = DLE_BYTE;
                    k = k + CNT_W'(1);
                end
                n_run.bytes[k[IDX_W-1:0]] = i_in.payload_byte;
                k = k + CNT_W'(1);
            end
            if (i_in.last) begin
                if (needs_dle(n_check)) begin
                    n_run.bytes[k[IDX_W-1:0]] = DLE_BYTE;
                    k = k + CNT_W'(1);
                end
                n_run.bytes[k[IDX_W-1:0]] = n_check;
                k = k + CNT_W'(1);
                n_run.bytes[k[IDX_W-1:0]] = END_BYTE;
                k = k + CNT_W'(1);
                n_run.has_end = 1'b1;
                n_in_frame    = 1'b0;
            end
        end

        n_run.count = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_check     <= '0;
            r_run_valid <= 1'b0;
        end else if (accept) begin
            r_in_frame  <= n_in_frame;
            r_check     <= n_check;
            // an item that causes no bytes leaves nothing to hand on
            r_run_valid <= (n_run.count != '0);
        end else if (i_run_ready) begin
            r_run_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_run <= n_run;
        end
    end

endmodule

/* src/dsfe_serializer.sv */
module dsfe_serializer
    import dsfe_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_run_valid,
    input  t_run         i_run,
    output logic         o_run_ready,
    dsfe_out_if.source   o_out
);

    t_run_bytes       r_buf;
    logic [CNT_W-1:0] r_cnt;
    logic             r_end;
    logic             take;
    logic             load;
    logic             last_byte;

    assign last_byte   = (r_cnt == CNT_W'(1));
    assign take        = o_out.valid && o_out.ready;
    // take the next run while the last byte of this one leaves
    assign o_run_ready = (r_cnt == '0) || (last_byte && o_out.ready);
    assign load        = i_run_valid && o_run_ready;

    assign o_out.valid     = (r_cnt != '0);
    assign o_out.out_byte  = r_buf[0];
    assign o_out.run_last  = last_byte;
    assign o_out.frame_end = r_end && last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (load) begin
            r_cnt <= i_run.count;
        end else if (take) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_buf <= i_run.bytes;
            r_end <= i_run.has_end;
        end else if (take) begin
            r_buf <= r_buf >> 8;
        end
    end

endmodule

/* src/dle_stuffed_frame_encoder.sv */
// Byte-stuffed frame encoder with an XOR check byte. Each accepted item is
// turned into a registered run of zero to eight output bytes (header on the
// first item, the payload byte with a leading 0x10 when it collides with a
// control byte, and the stuffed check byte plus 0xAA on the last item), which
// a shift-register serializer sends out one byte per cycle while the output
// is ready. An item occupies the output for as many bytes as it causes: one
// or two for a plain payload byte, up to eight for a one-item frame; items
// that cause no bytes send nothing on. The run register and the serializer
// overlap: the next item is taken as the last byte of a run leaves, and the
// output stays busy every cycle under load of byte-causing items. run_last
// marks the final byte of each item's run, frame_end marks the closing 0xAA.
module dle_stuffed_frame_encoder
    import dsfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    dsfe_in_if.sink     i_in,
    dsfe_out_if.source  o_out
);

    logic run_valid;
    logic run_ready;
    t_run run;

    dsfe_framer u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_run_valid (run_valid),
        .o_run       (run),
        .i_run_ready (run_ready)
    );

    dsfe_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run_valid (run_valid),
        .i_run       (run),
        .o_run_ready (run_ready),
        .o_out       (o_out)
    );

endmodule

/* src/dsfe_checker.sv */
module dsfe_checker
    import dsfe_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_run_last,
    input logic       i_out_frame_end
);

    // hold a stalled output byte
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte))
        else $error("output byte changed while stalled");

    a_end_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_frame_end |-> (i_out_byte == END_BYTE) && i_out_run_last)
        else $error("frame end flag on a byte that does not close the run");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // an idle output can always take a new item
    a_ready_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid && $past(!i_out_valid) && $past(i_rst_n) && $past(!i_in_valid)
        |-> i_in_ready)
        else $error("input stalled with nothing in flight");

endmodule

bind dle_stuffed_frame_encoder dsfe_checker u_dsfe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_byte      (o_out.out_byte),
    .i_out_run_last  (o_out.run_last),
    .i_out_frame_end (o_out.frame_end)
);
